[rtl/core/bgms_pkg.sv]
// ----------------------------------------------------------------------------
// Binary grid majority smoother package
// Shared widths, register indexes and types of the grid smoother.
// ----------------------------------------------------------------------------
package bgms_pkg;

	localparam int ROW_BITS        = 64;
	localparam int WIDTH_BITS      = 7;
	localparam int THRESH_BITS     = 4;
	localparam int COUNT_BITS      = 4;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 7;

	localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH     = 7'd64;
	localparam logic [THRESH_BITS-1:0] RESET_THRESHOLD = 4'd5;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROW_WIDTH      = 2'd0,
		REG_WALL_THRESHOLD = 2'd1
	} cfg_reg_t;

	// Three-cell slices of the rows above, at and below one cell.
	typedef struct packed {
		logic [2:0] above;
		logic [2:0] here;
		logic [2:0] below;
	} window_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] row;
		logic                last;
	} result_t;

endpackage

[rtl/core/bgms_lane.sv]
// ----------------------------------------------------------------------------
// Smoother lane
// Counts the walls in one 3x3 window and compares against the threshold.
// ----------------------------------------------------------------------------
module bgms_lane (
	input  bgms_pkg::window_t                     win,
	input  logic [bgms_pkg::THRESH_BITS-1:0]      threshold,
	output logic                                  wall
);
	import bgms_pkg::*;

	logic [COUNT_BITS-1:0] count;

	assign count = COUNT_BITS'(win.above[0]) + COUNT_BITS'(win.above[1])
		+ COUNT_BITS'(win.above[2]) + COUNT_BITS'(win.here[0])
		+ COUNT_BITS'(win.here[1]) + COUNT_BITS'(win.here[2])
		+ COUNT_BITS'(win.below[0]) + COUNT_BITS'(win.below[1])
		+ COUNT_BITS'(win.below[2]);

	assign wall = (count >= threshold);

endmodule

[rtl/core/bgms_row_smoother.sv]
// ----------------------------------------------------------------------------
// Row smoother
// One lane per cell of a row, with border walls around the used width, and
// a merge that gathers the lane results into the masked output row.
// ----------------------------------------------------------------------------
module bgms_row_smoother #(
	parameter int MAX_ROW_CELLS = 64
) (
	input  logic [MAX_ROW_CELLS-1:0]              above,
	input  logic [MAX_ROW_CELLS-1:0]              here,
	input  logic [MAX_ROW_CELLS-1:0]              below,
	input  logic [MAX_ROW_CELLS-1:0]              mask,
	input  logic [bgms_pkg::THRESH_BITS-1:0]      threshold,
	output logic [MAX_ROW_CELLS-1:0]              row
);
	import bgms_pkg::*;

	logic [MAX_ROW_CELLS+1:0] pad_above;
	logic [MAX_ROW_CELLS+1:0] pad_here;
	logic [MAX_ROW_CELLS+1:0] pad_below;
	logic [MAX_ROW_CELLS-1:0] lane_wall;

	// Cells outside the used width, and on both ends, read as walls.
	assign pad_above = {1'b1, (above & mask) | ~mask, 1'b1};
	assign pad_here  = {1'b1, (here & mask) | ~mask, 1'b1};
	assign pad_below = {1'b1, (below & mask) | ~mask, 1'b1};

	for (genvar i = 0; i < MAX_ROW_CELLS; i++) begin : g_lane
		window_t win;
		assign win.above = pad_above[i+2:i];
		assign win.here  = pad_here[i+2:i];
		assign win.below = pad_below[i+2:i];
		bgms_lane u_lane (
			.win       (win),
			.threshold (threshold),
			.wall      (lane_wall[i])
		);
	end

	assign row = lane_wall & mask;

endmodule

[rtl/core/binary_grid_majority_smoother_core.sv]
// ----------------------------------------------------------------------------
// Binary grid majority smoother core
// One smoothing pass of a wall/floor grid streamed as whole rows.
// ----------------------------------------------------------------------------
// A row is accepted in every cycle while the four-entry result queue has at
// least two free entries. Both possible results of a row, the smoothed middle
// row and, on the bottom row, the flushed bottom row, are computed by two
// banks of per-cell lanes in the accept cycle and written to the queue; a
// result beat is offered once it is registered in the queue. The first
// row of a grid gives no result, each later row one, and the bottom row one
// more marked with last_of_frame. Cells outside the grid count as walls. The
// input stalls only while more than two results wait in the queue, which
// happens only when the output side holds off.
module binary_grid_majority_smoother_core #(
	parameter int MAX_ROW_CELLS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [bgms_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [bgms_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [bgms_pkg::ROW_BITS-1:0]         row_cells,
	input  logic                                  last_row,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [bgms_pkg::ROW_BITS-1:0]         smoothed_row,
	output logic                                  last_of_frame
);
	import bgms_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH_BITS-1:0]    row_width_q;
	logic [THRESH_BITS-1:0]   threshold_q;
	logic [MAX_ROW_CELLS-1:0] upper_q;
	logic [MAX_ROW_CELLS-1:0] middle_q;
	logic                     have_middle_q;

	logic [WIDTH_BITS-1:0]    eff_width;
	logic [MAX_ROW_CELLS-1:0] mask;
	logic [MAX_ROW_CELLS-1:0] row_in;
	logic [MAX_ROW_CELLS-1:0] above_b;
	logic [MAX_ROW_CELLS-1:0] res_a_row;
	logic [MAX_ROW_CELLS-1:0] res_b_row;
	result_t                  res_a;
	result_t                  res_b;

	result_t                  fifo_q [DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [CNT_W-1:0]         count_q;
	logic [PTR_W-1:0]         b_ptr;
	logic                     accept;
	logic                     push_a;
	logic                     push_b;
	logic                     pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= RESET_WIDTH;
			threshold_q <= RESET_THRESHOLD;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_WIDTH: begin
					row_width_q <= cfg_data[WIDTH_BITS-1:0];
				end
				REG_WALL_THRESHOLD: begin
					threshold_q <= cfg_data[THRESH_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		eff_width = row_width_q;
		if (row_width_q == '0) begin
			eff_width = WIDTH_BITS'(1);
		end else if (row_width_q > WIDTH_BITS'(MAX_ROW_CELLS)) begin
			eff_width = WIDTH_BITS'(MAX_ROW_CELLS);
		end
	end

	for (genvar i = 0; i < MAX_ROW_CELLS; i++) begin : g_mask
		assign mask[i] = (WIDTH_BITS'(i) < eff_width);
	end

	assign row_in  = row_cells[MAX_ROW_CELLS-1:0];
	assign above_b = have_middle_q ? middle_q : '1;

	// Middle row smoothed against the incoming row.
	bgms_row_smoother #(
		.MAX_ROW_CELLS (MAX_ROW_CELLS)
	) u_smooth_a (
		.above     (upper_q),
		.here      (middle_q),
		.below     (row_in),
		.mask      (mask),
		.threshold (threshold_q),
		.row       (res_a_row)
	);

	// Incoming bottom row smoothed against a wall row below it.
	bgms_row_smoother #(
		.MAX_ROW_CELLS (MAX_ROW_CELLS)
	) u_smooth_b (
		.above     (above_b),
		.here      (row_in),
		.below     ('1),
		.mask      (mask),
		.threshold (threshold_q),
		.row       (res_b_row)
	);

	assign res_a.row  = ROW_BITS'(res_a_row);
	assign res_a.last = 1'b0;
	assign res_b.row  = ROW_BITS'(res_b_row);
	assign res_b.last = 1'b1;

	assign in_ready = (count_q <= CNT_W'(DEPTH - 2));
	assign accept   = in_valid & in_ready;
	assign push_a   = accept & have_middle_q;
	assign push_b   = accept & last_row;
	assign out_valid = (count_q != '0);
	assign pop      = out_valid & out_ready;
	assign b_ptr    = push_a ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;

	// Row history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q       <= '1;
			middle_q      <= '0;
			have_middle_q <= 1'b0;
		end else if (accept) begin
			if (last_row) begin
				upper_q       <= '1;
				middle_q      <= '0;
				have_middle_q <= 1'b0;
			end else if (!have_middle_q) begin
				upper_q       <= '1;
				middle_q      <= row_in;
				have_middle_q <= 1'b1;
			end else begin
				upper_q  <= middle_q;
				middle_q <= row_in;
			end
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (push_a) begin
			fifo_q[wr_ptr_q] <= res_a;
		end
		if (push_b) begin
			fifo_q[b_ptr] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_a) + PTR_W'(push_b);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
		end
	end

	assign smoothed_row  = fifo_q[rd_ptr_q].row;
	assign last_of_frame = fifo_q[rd_ptr_q].last;

endmodule
